@@ hdl/frwt_pkg.sv @@
// ----------------------------------------------------------------------------
// frwt_pkg: shared types and constants of the frequency whitelist table
// Field widths, operation and status codes, and the structures that pass
// between the top level and the row of table cells.
// ----------------------------------------------------------------------------
`default_nettype none

package frwt_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 64;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned HZ_W    = 40;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned BATCH_W = 16;

  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CHECK  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  localparam logic [ID_W-1:0]    FIRST_ID  = 32'd1;
  localparam logic [BATCH_W-1:0] BATCH_MAX = 16'hFFFF;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            enable;
    logic [HZ_W-1:0] low_hz;
    logic [HZ_W-1:0] high_hz;
  } entry_t;

  typedef struct packed {
    logic            is_check;
    logic [ID_W-1:0] id;
    logic [HZ_W-1:0] low_hz;
    logic [HZ_W-1:0] high_hz;
  } query_t;

  typedef struct packed {
    logic   wr_en;
    logic   shift_en;
    entry_t data;
  } cell_ctrl_t;

  typedef struct packed {
    logic   valid;
    logic   found;
    entry_t entry;
  } probe_t;

endpackage

`default_nettype wire

@@ hdl/frequency_range_whitelist_table.sv @@
// ----------------------------------------------------------------------------
// frequency_range_whitelist_table: ordered frequency whitelist with matching
// Add, delete, update and clear table entries, and check detected objects
// against the first enabled overlapping entry.
// ----------------------------------------------------------------------------
// Usage: each input word carries one operation selected by mode_i and gives
// exactly one output word. Both channels use valid/ready handshakes.
// Every word sends a probe down the row of TABLE_DEPTH cells, one cell per
// cycle, so that the first matching entry in table order is found; the
// table is then written or compacted. A new word is accepted only once the
// previous one has finished. Words are worked on one at a time.
// The result sits in an output register, so the next word is taken while a
// result waits; if the receiver still stalls when the following result is
// ready, the block holds that result and the table update until the output
// register is free.
// Reset empties the table, sets the next id to one and clears the batch
// counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module frequency_range_whitelist_table #(
  parameter int unsigned TABLE_DEPTH = frwt_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [frwt_pkg::MODE_W-1:0]      mode_i,
  input  wire logic [frwt_pkg::ID_W-1:0]        entry_id_i,
  input  wire logic                             entry_enable_i,
  input  wire logic [frwt_pkg::HZ_W-1:0]        range_low_hz_i,
  input  wire logic [frwt_pkg::HZ_W-1:0]        range_high_hz_i,
  input  wire logic [frwt_pkg::ID_W-1:0]        track_id_i,
  input  wire logic                             last_object_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [frwt_pkg::STAT_W-1:0]      status_o,
  output logic      [frwt_pkg::ID_W-1:0]        assigned_id_o,
  output logic      [frwt_pkg::BATCH_W-1:0]     object_index_o,
  output logic                                  matched_o,
  output logic      [frwt_pkg::ID_W-1:0]        whitelist_id_o,
  output logic      [frwt_pkg::HZ_W-1:0]        canonical_low_hz_o,
  output logic      [frwt_pkg::HZ_W-1:0]        canonical_high_hz_o,
  output logic      [frwt_pkg::ID_W-1:0]        track_id_out_o,
  output logic      [frwt_pkg::BATCH_W-1:0]     match_count_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       start_q;

  logic [frwt_pkg::MODE_W-1:0]  mode_q;
  logic [frwt_pkg::ID_W-1:0]    eid_q;
  logic                         en_q;
  logic [frwt_pkg::HZ_W-1:0]    lo_q;
  logic [frwt_pkg::HZ_W-1:0]    hi_q;
  logic [frwt_pkg::ID_W-1:0]    tid_q;
  logic                         last_q;

  logic [CNT_W-1:0]             used_q, used_d;
  logic [frwt_pkg::ID_W-1:0]    next_id_q, next_id_d;
  logic [frwt_pkg::BATCH_W-1:0] bidx_q, bidx_d;
  logic [frwt_pkg::BATCH_W-1:0] bmatch_q, bmatch_d;
  logic [frwt_pkg::BATCH_W-1:0] bmatch_new;

  logic                          out_valid_q, out_valid_d;
  logic [frwt_pkg::STAT_W-1:0]   status_q, status_d;
  logic [frwt_pkg::ID_W-1:0]     assigned_q, assigned_d;
  logic [frwt_pkg::BATCH_W-1:0]  oidx_q, oidx_d;
  logic                          matched_q, matched_d;
  logic [frwt_pkg::ID_W-1:0]     wid_q, wid_d;
  logic [frwt_pkg::HZ_W-1:0]     clo_q, clo_d;
  logic [frwt_pkg::HZ_W-1:0]     chi_q, chi_d;
  logic [frwt_pkg::ID_W-1:0]     tido_q, tido_d;
  logic [frwt_pkg::BATCH_W-1:0]  mcount_q, mcount_d;

  frwt_pkg::query_t     query;
  frwt_pkg::cell_ctrl_t ctrl;
  logic [IDX_W-1:0]     wr_idx;
  logic                 accept;
  logic                 do_finish;
  logic                 table_full;

  frwt_pkg::probe_t     probe [TABLE_DEPTH+1];
  logic [IDX_W-1:0]     pidx  [TABLE_DEPTH+1];
  frwt_pkg::entry_t     ent   [TABLE_DEPTH];

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign do_finish  = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign table_full = (used_q == CNT_W'(TABLE_DEPTH)) || (next_id_q == '0);

  assign query = '{is_check: (mode_q == frwt_pkg::MODE_CHECK), id: eid_q,
                   low_hz: lo_q, high_hz: hi_q};

  assign probe[0] = '{valid: start_q, found: 1'b0, entry: '0};
  assign pidx[0]  = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    frwt_cell #(
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .CELL_INDEX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .used_i       (used_q),
      .query_i      (query),
      .ctrl_i       (ctrl),
      .wr_idx_i     (wr_idx),
      .shift_from_i (pidx[TABLE_DEPTH]),
      .nbr_entry_i  (ent[(g + 1 < TABLE_DEPTH) ? g + 1 : g]),
      .entry_o      (ent[g]),
      .probe_i      (probe[g]),
      .probe_idx_i  (pidx[g]),
      .probe_o      (probe[g+1]),
      .probe_idx_o  (pidx[g+1])
    );
  end

  assign bmatch_new = (probe[TABLE_DEPTH].found && bmatch_q != frwt_pkg::BATCH_MAX) ?
                      bmatch_q + 16'd1 : bmatch_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (probe[TABLE_DEPTH].valid) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (do_finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl        = '0;
    wr_idx      = used_q[IDX_W-1:0];
    used_d      = used_q;
    next_id_d   = next_id_q;
    bidx_d      = bidx_q;
    bmatch_d    = bmatch_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    assigned_d  = assigned_q;
    oidx_d      = oidx_q;
    matched_d   = matched_q;
    wid_d       = wid_q;
    clo_d       = clo_q;
    chi_d       = chi_q;
    tido_d      = tido_q;
    mcount_d    = mcount_q;
    if (do_finish) begin
      out_valid_d = 1'b1;
      status_d    = frwt_pkg::STAT_OK;
      assigned_d  = '0;
      oidx_d      = '0;
      matched_d   = 1'b0;
      wid_d       = '0;
      clo_d       = '0;
      chi_d       = '0;
      tido_d      = '0;
      mcount_d    = '0;
      unique case (mode_q)
        frwt_pkg::MODE_ADD: begin
          if (table_full) begin
            status_d = frwt_pkg::STAT_FULL;
          end else begin
            ctrl.wr_en = 1'b1;
            ctrl.data  = '{id: next_id_q, enable: en_q, low_hz: lo_q, high_hz: hi_q};
            used_d     = used_q + CNT_W'(1);
            next_id_d  = next_id_q + 32'd1;
            assigned_d = next_id_q;
          end
        end
        frwt_pkg::MODE_DELETE: begin
          if (!probe[TABLE_DEPTH].found) begin
            status_d = frwt_pkg::STAT_NOT_FOUND;
          end else begin
            ctrl.shift_en = 1'b1;
            used_d        = used_q - CNT_W'(1);
          end
        end
        frwt_pkg::MODE_UPDATE: begin
          if (!probe[TABLE_DEPTH].found) begin
            status_d = frwt_pkg::STAT_NOT_FOUND;
          end else begin
            ctrl.wr_en = 1'b1;
            ctrl.data  = '{id: eid_q, enable: en_q, low_hz: lo_q, high_hz: hi_q};
            wr_idx     = pidx[TABLE_DEPTH];
          end
        end
        frwt_pkg::MODE_CLEAR: begin
          used_d    = '0;
          next_id_d = frwt_pkg::FIRST_ID;
        end
        frwt_pkg::MODE_CHECK: begin
          oidx_d    = bidx_q;
          matched_d = probe[TABLE_DEPTH].found;
          tido_d    = tid_q;
          mcount_d  = bmatch_new;
          if (probe[TABLE_DEPTH].found) begin
            wid_d = probe[TABLE_DEPTH].entry.id;
            clo_d = probe[TABLE_DEPTH].entry.low_hz;
            chi_d = probe[TABLE_DEPTH].entry.high_hz;
          end else begin
            clo_d = lo_q;
            chi_d = hi_q;
          end
          if (last_q) begin
            bidx_d   = '0;
            bmatch_d = '0;
          end else begin
            bmatch_d = bmatch_new;
            bidx_d   = (bidx_q != frwt_pkg::BATCH_MAX) ? bidx_q + 16'd1 : bidx_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      used_q      <= '0;
      next_id_q   <= frwt_pkg::FIRST_ID;
      bidx_q      <= '0;
      bmatch_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= accept;
      used_q      <= used_d;
      next_id_q   <= next_id_d;
      bidx_q      <= bidx_d;
      bmatch_q    <= bmatch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      eid_q  <= entry_id_i;
      en_q   <= entry_enable_i;
      lo_q   <= range_low_hz_i;
      hi_q   <= range_high_hz_i;
      tid_q  <= track_id_i;
      last_q <= last_object_i;
    end
    status_q   <= status_d;
    assigned_q <= assigned_d;
    oidx_q     <= oidx_d;
    matched_q  <= matched_d;
    wid_q      <= wid_d;
    clo_q      <= clo_d;
    chi_q      <= chi_d;
    tido_q     <= tido_d;
    mcount_q   <= mcount_d;
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign assigned_id_o       = assigned_q;
  assign object_index_o      = oidx_q;
  assign matched_o           = matched_q;
  assign whitelist_id_o      = wid_q;
  assign canonical_low_hz_o  = clo_q;
  assign canonical_high_hz_o = chi_q;
  assign track_id_out_o      = tido_q;
  assign match_count_o       = mcount_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(TABLE_DEPTH))
    else $error("table fill count exceeds the table depth");

  a_probe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probe[TABLE_DEPTH].valid |-> state_q == ST_SCAN)
    else $error("probe left the cell row outside a scan");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_SCAN && start_q)
    else $error("accepted word did not start a scan");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
    else $error("result appeared without a finished operation");

endmodule

`default_nettype wire

@@ hdl/frwt_cell.sv @@
// ----------------------------------------------------------------------------
// frwt_cell: one slot of the whitelist table
// Holds one entry, takes writes and compaction shifts from its upper
// neighbour, and passes the search probe on to the next cell each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frwt_cell #(
  parameter int unsigned IDX_W      = 6,
  parameter int unsigned CNT_W      = 7,
  parameter int unsigned CELL_INDEX = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [CNT_W-1:0]    used_i,
  input  frwt_pkg::query_t         query_i,
  input  frwt_pkg::cell_ctrl_t     ctrl_i,
  input  wire logic [IDX_W-1:0]    wr_idx_i,
  input  wire logic [IDX_W-1:0]    shift_from_i,
  input  frwt_pkg::entry_t         nbr_entry_i,
  output frwt_pkg::entry_t         entry_o,
  input  frwt_pkg::probe_t         probe_i,
  input  wire logic [IDX_W-1:0]    probe_idx_i,
  output frwt_pkg::probe_t         probe_o,
  output logic      [IDX_W-1:0]    probe_idx_o
);

  frwt_pkg::entry_t entry_q;
  logic             valid_q;
  logic             found_q;
  frwt_pkg::entry_t pentry_q;
  logic [IDX_W-1:0] pidx_q;
  logic             occupied;
  logic             overlap;
  logic             match;

  assign occupied = CNT_W'(CELL_INDEX) < used_i;
  assign overlap  = entry_q.enable &&
                    !(query_i.high_hz < entry_q.low_hz || query_i.low_hz > entry_q.high_hz);
  assign match    = occupied && (query_i.is_check ? overlap : (entry_q.id == query_i.id));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && wr_idx_i == IDX_W'(CELL_INDEX)) begin
      entry_q <= ctrl_i.data;
    end else if (ctrl_i.shift_en && IDX_W'(CELL_INDEX) >= shift_from_i) begin
      entry_q <= nbr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= probe_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (probe_i.valid) begin
      if (probe_i.found) begin
        found_q  <= 1'b1;
        pentry_q <= probe_i.entry;
        pidx_q   <= probe_idx_i;
      end else begin
        found_q  <= match;
        pentry_q <= entry_q;
        pidx_q   <= IDX_W'(CELL_INDEX);
      end
    end
  end

  assign entry_o     = entry_q;
  assign probe_o     = '{valid: valid_q, found: found_q, entry: pentry_q};
  assign probe_idx_o = pidx_q;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the frequency range whitelist table
// A directed table walks through every operation and the corner cases of the
// table, then phases of random words fill, churn and drain it. Each accepted
// word is run through a behavioural copy of the table, and every output word
// is compared field by field with the oldest expected result. Both channels
// idle and stall at random, with one stretch of full throughput.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import frwt_pkg::*;

  localparam int unsigned DEPTH          = DEFAULT_TABLE_DEPTH;
  localparam int          RANDOM_WORDS   = 1650;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          MAX_REPORTS    = 200;

  localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  localparam logic [ID_W-1:0] ID_MAX = '1;
  localparam logic [HZ_W-1:0] HZ_MAX = '1;

  localparam int BIAS_FILL  = 0;
  localparam int BIAS_MIXED = 1;
  localparam int BIAS_DRAIN = 2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   entry_id;
    logic              enable;
    logic [HZ_W-1:0]   low_hz;
    logic [HZ_W-1:0]   high_hz;
    logic [ID_W-1:0]   trk;
    logic              last;
  } word_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ID_W-1:0]    assigned_id;
    logic [BATCH_W-1:0] batch_pos;
    logic               matched;
    logic [ID_W-1:0]    hit_id;
    logic [HZ_W-1:0]    canonical_low;
    logic [HZ_W-1:0]    canonical_high;
    logic [ID_W-1:0]    track_echo;
    logic [BATCH_W-1:0] hit_count;
  } result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [MODE_W-1:0]  mode         = MODE_CLEAR;
  logic [ID_W-1:0]    entry_id     = '0;
  logic               entry_enable = 1'b0;
  logic [HZ_W-1:0]    range_low    = '0;
  logic [HZ_W-1:0]    range_high   = '0;
  logic [ID_W-1:0]    trk_in       = '0;
  logic               last_object  = 1'b0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [STAT_W-1:0]  status;
  logic [ID_W-1:0]    assigned_id;
  logic [BATCH_W-1:0] batch_pos;
  logic               matched;
  logic [ID_W-1:0]    hit_id;
  logic [HZ_W-1:0]    canon_low;
  logic [HZ_W-1:0]    canon_high;
  logic [ID_W-1:0]    track_out;
  logic [BATCH_W-1:0] hit_count;

  result_t seen;
  assign seen = {status, assigned_id, batch_pos, matched, hit_id,
                 canon_low, canon_high, track_out, hit_count};

  frequency_range_whitelist_table #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .mode_i             (mode),
    .entry_id_i         (entry_id),
    .entry_enable_i     (entry_enable),
    .range_low_hz_i     (range_low),
    .range_high_hz_i    (range_high),
    .track_id_i         (trk_in),
    .last_object_i      (last_object),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .status_o           (status),
    .assigned_id_o      (assigned_id),
    .object_index_o     (batch_pos),
    .matched_o          (matched),
    .whitelist_id_o     (hit_id),
    .canonical_low_hz_o (canon_low),
    .canonical_high_hz_o(canon_high),
    .track_id_out_o     (track_out),
    .match_count_o      (hit_count)
  );

  // Behavioural copy of the table and the batch counters.
  logic [ID_W-1:0]    wl_id [DEPTH];
  logic               wl_en [DEPTH];
  logic [HZ_W-1:0]    wl_lo [DEPTH];
  logic [HZ_W-1:0]    wl_hi [DEPTH];
  int                 wl_count    = 0;
  logic [ID_W-1:0]    wl_next_id  = FIRST_ID;
  logic [BATCH_W-1:0] obj_index   = '0;
  logic [BATCH_W-1:0] obj_matches = '0;

  result_t pending_results [$];
  word_t   dir_words [$];
  bit      dir_typed [$];
  result_t dir_expect [$];

  int errors       = 0;
  int stuck_cycles = 0;
  int stall_left   = 0;
  bit quiet        = 1'b0;

  function automatic result_t whitelist_apply(word_t w);
    result_t r;
    int      k;
    int      i;
    logic    hit;
    r   = '0;
    k   = -1;
    hit = 1'b0;
    case (w.mode)
      MODE_ADD: begin
        if (wl_count >= DEPTH || wl_next_id == '0) begin
          r.status = STAT_FULL;
        end else begin
          wl_id[wl_count] = wl_next_id;
          wl_en[wl_count] = w.enable;
          wl_lo[wl_count] = w.low_hz;
          wl_hi[wl_count] = w.high_hz;
          wl_count++;
          r.assigned_id = wl_next_id;
          wl_next_id++;
        end
      end
      MODE_DELETE, MODE_UPDATE: begin
        for (i = 0; i < wl_count; i++) begin
          if (k < 0 && wl_id[i] == w.entry_id) k = i;
        end
        if (k < 0) begin
          r.status = STAT_NOT_FOUND;
        end else if (w.mode == MODE_UPDATE) begin
          wl_en[k] = w.enable;
          wl_lo[k] = w.low_hz;
          wl_hi[k] = w.high_hz;
        end else begin
          for (i = k; i + 1 < wl_count; i++) begin
            wl_id[i] = wl_id[i+1];
            wl_en[i] = wl_en[i+1];
            wl_lo[i] = wl_lo[i+1];
            wl_hi[i] = wl_hi[i+1];
          end
          wl_count--;
        end
      end
      MODE_CLEAR: begin
        wl_count   = 0;
        wl_next_id = FIRST_ID;
      end
      MODE_CHECK: begin
        r.canonical_low  = w.low_hz;
        r.canonical_high = w.high_hz;
        for (i = 0; i < wl_count; i++) begin
          if (!hit && wl_en[i] && !(w.high_hz < wl_lo[i] || w.low_hz > wl_hi[i])) begin
            hit              = 1'b1;
            r.hit_id         = wl_id[i];
            r.canonical_low  = wl_lo[i];
            r.canonical_high = wl_hi[i];
          end
        end
        if (hit && obj_matches != BATCH_MAX) obj_matches++;
        r.batch_pos  = obj_index;
        r.matched    = hit;
        r.track_echo = w.trk;
        r.hit_count  = obj_matches;
        if (w.last) begin
          obj_index   = '0;
          obj_matches = '0;
        end else if (obj_index != BATCH_MAX) begin
          obj_index++;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [HZ_W-1:0] rand_hz();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return HZ_MAX;
      2, 3:    return wide[HZ_W-1:0];
      default: return HZ_W'($urandom_range(0, 4000));
    endcase
  endfunction

  function automatic word_t mk_word(logic [MODE_W-1:0] m, logic [ID_W-1:0] eid,
                                    logic en, logic [HZ_W-1:0] lo,
                                    logic [HZ_W-1:0] hi, logic [ID_W-1:0] tid,
                                    logic last);
    word_t w;
    w = '{mode: m, entry_id: eid, enable: en, low_hz: lo, high_hz: hi,
          trk: tid, last: last};
    return w;
  endfunction

  function automatic result_t mk_res(logic [STAT_W-1:0] st, logic [ID_W-1:0] aid,
                                     logic [BATCH_W-1:0] idx, logic hit,
                                     logic [ID_W-1:0] wid, logic [HZ_W-1:0] clo,
                                     logic [HZ_W-1:0] chi, logic [ID_W-1:0] tid,
                                     logic [BATCH_W-1:0] cnt);
    result_t r;
    r = '{status: st, assigned_id: aid, batch_pos: idx, matched: hit,
          hit_id: wid, canonical_low: clo, canonical_high: chi,
          track_echo: tid, hit_count: cnt};
    return r;
  endfunction

  task automatic dir_row(input word_t w, input bit typed, input result_t r);
    dir_words.insert(dir_words.size(), w);
    dir_typed.insert(dir_typed.size(), typed);
    dir_expect.insert(dir_expect.size(), r);
  endtask

  task automatic report_field(input string name, input logic [63:0] e,
                              input logic [63:0] g);
    if (errors < MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, g);
    end
    errors++;
  endtask

  task automatic send_word(input word_t w, input bit typed, input result_t given);
    result_t predicted;
    if (!quiet) begin
      if ($urandom_range(0, 19) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 90)) @(posedge clk_i);
      end else begin
        while ($urandom_range(0, 99) < 29) begin
          in_valid <= 1'b0;
          @(posedge clk_i);
        end
      end
    end
    in_valid     <= 1'b1;
    mode         <= w.mode;
    entry_id     <= w.entry_id;
    entry_enable <= w.enable;
    range_low    <= w.low_hz;
    range_high   <= w.high_hz;
    trk_in       <= w.trk;
    last_object  <= w.last;
    do @(posedge clk_i); while (!in_ready);
    predicted = whitelist_apply(w);
    pending_results.insert(pending_results.size(), typed ? given : predicted);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: short random stalls, the odd long one, none while quiet is set.
  initial begin
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 799) == 0) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(20, 160);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 29);
      end
    end
  end

  result_t oldest;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (errors < MAX_REPORTS) begin
          $display("%0t: output word with nothing expected, actual %0h", $time, seen);
        end
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (seen.status !== oldest.status)
          report_field("status", oldest.status, seen.status);
        if (seen.assigned_id !== oldest.assigned_id)
          report_field("assigned id", oldest.assigned_id, seen.assigned_id);
        if (seen.batch_pos !== oldest.batch_pos)
          report_field("batch position", oldest.batch_pos, seen.batch_pos);
        if (seen.matched !== oldest.matched)
          report_field("matched", oldest.matched, seen.matched);
        if (seen.hit_id !== oldest.hit_id)
          report_field("hit id", oldest.hit_id, seen.hit_id);
        if (seen.canonical_low !== oldest.canonical_low)
          report_field("canonical low", oldest.canonical_low, seen.canonical_low);
        if (seen.canonical_high !== oldest.canonical_high)
          report_field("canonical high", oldest.canonical_high, seen.canonical_high);
        if (seen.track_echo !== oldest.track_echo)
          report_field("track echo", oldest.track_echo, seen.track_echo);
        if (seen.hit_count !== oldest.hit_count)
          report_field("hit count", oldest.hit_count, seen.hit_count);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int    n;
    int    i;
    int    len;
    int    bias;
    int    p;
    int    c_add;
    int    c_chk;
    int    c_upd;
    int    c_del;
    int    c_uns;
    word_t w;

    dir_row(mk_word(MODE_CHECK, 0, 0, 100, 200, ID_MAX, 0), 1,
            mk_res(STAT_OK, 0, 0, 0, 0, 100, 200, ID_MAX, 0));
    dir_row(mk_word(MODE_ADD, 0, 1, 0, HZ_MAX, 0, 0), 1,
            mk_res(STAT_OK, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_row(mk_word(MODE_ADD, 0, 0, 1000, 2000, 0, 0), 1,
            mk_res(STAT_OK, 2, 0, 0, 0, 0, 0, 0, 0));
    dir_row(mk_word(MODE_ADD, 0, 1, HZ_MAX, HZ_MAX, 0, 0), 1,
            mk_res(STAT_OK, 3, 0, 0, 0, 0, 0, 0, 0));
    dir_row(mk_word(MODE_ADD, 0, 1, 500, 100, 0, 0), 1,
            mk_res(STAT_OK, 4, 0, 0, 0, 0, 0, 0, 0));
    dir_row(mk_word(MODE_CHECK, 0, 0, 1500, 1500, 7, 0), 0, '0);
    dir_row(mk_word(MODE_UPDATE, 1, 0, 0, 0, 0, 0), 0, '0);
    dir_row(mk_word(MODE_CHECK, 0, 0, 1500, 1600, 8, 0), 0, '0);
    dir_row(mk_word(MODE_UPDATE, 2, 1, 1000, 2000, 0, 0), 0, '0);
    dir_row(mk_word(MODE_CHECK, 0, 0, 2000, 3000, 9, 1), 0, '0);
    dir_row(mk_word(MODE_CHECK, 0, 0, 250, 300, 10, 0), 0, '0);
    dir_row(mk_word(MODE_CHECK, 0, 0, HZ_MAX, HZ_MAX, ID_MAX, 0), 0, '0);
    dir_row(mk_word(MODE_CHECK, 0, 0, 2001, HZ_MAX - 1, 11, 1), 0, '0);
    dir_row(mk_word(MODE_DELETE, ID_MAX, 0, 0, 0, 0, 0), 1,
            mk_res(STAT_NOT_FOUND, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_row(mk_word(MODE_UPDATE, 0, 1, 5, 6, 0, 0), 1,
            mk_res(STAT_NOT_FOUND, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_row(mk_word(MODE_DELETE, 2, 0, 0, 0, 0, 0), 0, '0);
    dir_row(mk_word(MODE_DELETE, 2, 0, 0, 0, 0, 0), 1,
            mk_res(STAT_NOT_FOUND, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_row(mk_word(MODE_CHECK, 0, 0, 0, HZ_MAX, 32'hA5A5_A5A5, 1), 0, '0);
    dir_row(mk_word(MODE_RSVD5, ID_MAX, 1, HZ_MAX, HZ_MAX, ID_MAX, 1), 1, '0);
    dir_row(mk_word(MODE_RSVD6, ID_MAX, 1, HZ_MAX, HZ_MAX, ID_MAX, 1), 1, '0);
    dir_row(mk_word(MODE_RSVD7, ID_MAX, 1, HZ_MAX, HZ_MAX, ID_MAX, 1), 1, '0);
    dir_row(mk_word(MODE_CLEAR, ID_MAX, 1, HZ_MAX, HZ_MAX, ID_MAX, 1), 1, '0);
    dir_row(mk_word(MODE_ADD, 0, 1, 10, 20, 0, 0), 1,
            mk_res(STAT_OK, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_row(mk_word(MODE_CHECK, 0, 0, 15, 15, 12, 1), 0, '0);
    dir_row(mk_word(MODE_DELETE, 1, 0, 0, 0, 0, 0), 0, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < dir_words.size(); i++) begin
      send_word(dir_words[i], dir_typed[i], dir_expect[i]);
    end

    // Random phases that fill the table to the top, churn it or drain it.
    n = 0;
    while (n < RANDOM_WORDS) begin
      bias = $urandom_range(BIAS_FILL, BIAS_DRAIN);
      len  = $urandom_range(40, 140);
      case (bias)
        BIAS_FILL: begin
          c_add = 60; c_chk = 85; c_upd = 91; c_del = 97; c_uns = 100;
        end
        BIAS_MIXED: begin
          c_add = 25; c_chk = 70; c_upd = 82; c_del = 94; c_uns = 97;
        end
        default: begin
          c_add = 10; c_chk = 40; c_upd = 50; c_del = 95; c_uns = 98;
        end
      endcase
      repeat (len) begin
        quiet = (n >= 700 && n < 1000);
        w.entry_id = $urandom;
        w.enable   = ($urandom_range(0, 3) != 0);
        w.low_hz   = rand_hz();
        w.high_hz  = ($urandom_range(0, 4) != 0) ? w.low_hz + $urandom_range(0, 400)
                                                 : rand_hz();
        w.trk      = $urandom;
        w.last     = ($urandom_range(0, 3) == 0);
        p = $urandom_range(0, 99);
        if (p < c_add) begin
          w.mode = MODE_ADD;
        end else if (p < c_chk) begin
          w.mode = MODE_CHECK;
        end else if (p < c_upd) begin
          w.mode = MODE_UPDATE;
        end else if (p < c_del) begin
          w.mode = MODE_DELETE;
        end else if (p < c_uns) begin
          case ($urandom_range(0, 2))
            0:       w.mode = MODE_RSVD5;
            1:       w.mode = MODE_RSVD6;
            default: w.mode = MODE_RSVD7;
          endcase
        end else begin
          w.mode = MODE_CLEAR;
        end
        if (w.mode == MODE_DELETE || w.mode == MODE_UPDATE) begin
          if (wl_count > 0 && $urandom_range(0, 4) != 0) begin
            w.entry_id = wl_id[$urandom_range(0, wl_count - 1)];
          end else begin
            case ($urandom_range(0, 3))
              0:       w.entry_id = '0;
              1:       w.entry_id = ID_MAX;
              2:       w.entry_id = wl_next_id;
              default: ;
            endcase
          end
        end
        send_word(w, 1'b0, '0);
        n++;
      end
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * (DEPTH + 3)) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
